FILE: rtl/swa_pkg.sv
// Shared constants, widths and helper functions of the three-wheel swerve
// kinematics block. No dependencies.
package swa_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int SQRT_STEPS    = 16;
   localparam int WHEEL_STEPS   = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

   localparam int RADIUS_RESET = 300;
   localparam int SIN120_Q16   = 56756;
   localparam int MAG_LIM      = 32767;
   localparam int ANG_LIM      = 18000;

   // CORDIC datapath widths: samples scaled by 256 plus gain growth.
   localparam int CW = 27;
   localparam int ZW = 33;

   // Saturate a wide signed value to the symmetric 16-bit range.
   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      logic signed [15:0] r;
      if (v > 48'sd32767) begin
         r = 16'sd32767;
      end else if (v < -48'sd32767) begin
         r = -16'sd32767;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // atan(2^-i) in 0.01 degree, Q16, rounded.
   function automatic logic [31:0] atan_q16(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'd294912000;
         5'd1:  r = 32'd174096719;
         5'd2:  r = 32'd91987925;
         5'd3:  r = 32'd46694507;
         5'd4:  r = 32'd23437865;
         5'd5:  r = 32'd11730358;
         5'd6:  r = 32'd5866610;
         5'd7:  r = 32'd2933484;
         5'd8:  r = 32'd1466764;
         5'd9:  r = 32'd733385;
         5'd10: r = 32'd366693;
         5'd11: r = 32'd183346;
         5'd12: r = 32'd91673;
         5'd13: r = 32'd45837;
         5'd14: r = 32'd22918;
         5'd15: r = 32'd11459;
         5'd16: r = 32'd5730;
         5'd17: r = 32'd2865;
         5'd18: r = 32'd1432;
         5'd19: r = 32'd716;
         5'd20: r = 32'd358;
         5'd21: r = 32'd179;
         5'd22: r = 32'd90;
         5'd23: r = 32'd45;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/swa_kin.sv
// Three-stage kinematics front end: yaw term, per-wheel x/y components and
// saturation. Depends on swa_pkg.
module swa_kin (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [15:0] vel_x,
   input  logic signed [15:0] vel_y,
   input  logic signed [15:0] vel_w,
   input  logic        [9:0]  radius,
   output logic               out_valid,
   output logic signed [15:0] xa,
   output logic signed [15:0] ya,
   output logic signed [15:0] xb,
   output logic signed [15:0] yb,
   output logic signed [15:0] xc,
   output logic signed [15:0] yc
);

   logic [2:0] v_ff;

   // Stage 1
   logic signed [26:0] t_ff, t_in;
   logic signed [15:0] vx1_ff, vy1_ff;
   // Stage 2
   logic signed [44:0] p_ff, p_in;
   logic signed [15:0] xa2_ff, ya2_ff, xbc2_ff, vy2_ff;
   logic signed [15:0] xa2_in, ya2_in, xbc2_in;
   // Stage 3
   logic signed [15:0] xa3_ff, ya3_ff, xbc3_ff, yb3_ff, yc3_ff;
   logic signed [15:0] yb3_in, yc3_in;

   logic signed [47:0] tq, pq, vx2q, vy3q;

   assign t_in = vel_w * $signed({1'b0, radius});

   always_comb begin
      tq      = 48'(t_ff);
      vx2q    = 48'(vx1_ff);
      xa2_in  = swa_pkg::sat16(vx2q + ((tq + 48'sd2048) >>> 12));
      xbc2_in = swa_pkg::sat16(vx2q + ((48'sd4096 - tq) >>> 13));
      ya2_in  = swa_pkg::sat16(48'(vy1_ff));
      p_in    = t_ff * $signed(18'(swa_pkg::SIN120_Q16));
   end

   always_comb begin
      pq     = 48'(p_ff);
      vy3q   = 48'(vy2_ff);
      yb3_in = swa_pkg::sat16(vy3q + ((pq + 48'sd134217728) >>> 28));
      yc3_in = swa_pkg::sat16(vy3q + ((48'sd134217728 - pq) >>> 28));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff    <= t_in;
         vx1_ff  <= vel_x;
         vy1_ff  <= vel_y;
         p_ff    <= p_in;
         xa2_ff  <= xa2_in;
         ya2_ff  <= ya2_in;
         xbc2_ff <= xbc2_in;
         vy2_ff  <= vy1_ff;
         xa3_ff  <= xa2_ff;
         ya3_ff  <= ya2_ff;
         xbc3_ff <= xbc2_ff;
         yb3_ff  <= yb3_in;
         yc3_ff  <= yc3_in;
      end
   end

   assign out_valid = v_ff[2];
   assign xa = xa3_ff;
   assign ya = ya3_ff;
   assign xb = xbc3_ff;
   assign yb = yb3_ff;
   assign xc = xbc3_ff;
   assign yc = yc3_ff;

   // Saturation never lets the most negative code through.
   a_sat_x : assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (xa != -16'sd32768 && xb != -16'sd32768))
      else $error("unsaturated x component");

endmodule

FILE: rtl/swa_wheel.sv
// Per-wheel pipeline: restoring square root for the speed and a vectoring
// CORDIC for the steering angle, one step per stage. Depends on swa_pkg.
module swa_wheel (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [15:0] x,
   input  logic signed [15:0] y,
   output logic               out_valid,
   output logic        [15:0] speed,
   output logic signed [15:0] angle
);

   localparam int N  = swa_pkg::WHEEL_STEPS;
   localparam int CW = swa_pkg::CW;
   localparam int ZW = swa_pkg::ZW;

   logic                 v_ff  [N+1];
   logic                 zr_ff [N+1];
   logic [31:0]          sn_ff [N+1];
   logic [31:0]          sr_ff [N+1];
   logic signed [CW-1:0] cx_ff [N+1];
   logic signed [CW-1:0] cy_ff [N+1];
   logic signed [ZW-1:0] cz_ff [N+1];

   // Stage 0: squares and CORDIC half-plane fold.
   logic signed [CW-1:0] xs, ys, cx0_in, cy0_in;
   logic signed [ZW-1:0] cz0_in;
   logic signed [31:0]   xx, yy;
   logic [31:0]          sn0_in;

   always_comb begin
      xx     = x * x;
      yy     = y * y;
      sn0_in = 32'(xx) + 32'(yy);
      xs     = CW'(x) <<< 8;
      ys     = CW'(y) <<< 8;
      cx0_in = xs;
      cy0_in = ys;
      cz0_in = '0;
      if (x < 0) begin
         cx0_in = -xs;
         cy0_in = -ys;
         cz0_in = (y >= 0) ? ZW'(swa_pkg::ANG_LIM * 65536) : -ZW'(swa_pkg::ANG_LIM * 65536);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zr_ff[0] <= (x == 16'sd0) && (y == 16'sd0);
         sn_ff[0] <= sn0_in;
         sr_ff[0] <= '0;
         cx_ff[0] <= cx0_in;
         cy_ff[0] <= cy0_in;
         cz_ff[0] <= cz0_in;
      end
   end

   for (genvar j = 0; j < N; j++) begin : g_step
      logic [31:0]          sn_in, sr_in, trial;
      logic signed [CW-1:0] cx_in, cy_in;
      logic signed [ZW-1:0] cz_in, at;

      always_comb begin
         sn_in = sn_ff[j];
         sr_in = sr_ff[j];
         trial = '0;
         if (j < swa_pkg::SQRT_STEPS) begin
            trial = sr_ff[j] + (32'd1 << (30 - 2 * j));
            if (sn_ff[j] >= trial) begin
               sn_in = sn_ff[j] - trial;
               sr_in = (sr_ff[j] >> 1) + (32'd1 << (30 - 2 * j));
            end else begin
               sr_in = sr_ff[j] >> 1;
            end
         end
      end

      always_comb begin
         cx_in = cx_ff[j];
         cy_in = cy_ff[j];
         cz_in = cz_ff[j];
         at    = ZW'(swa_pkg::atan_q16(5'(j)));
         if (j < swa_pkg::CORDIC_STAGES) begin
            if (cy_ff[j] > 0) begin
               cx_in = cx_ff[j] + (cy_ff[j] >>> j);
               cy_in = cy_ff[j] - (cx_ff[j] >>> j);
               cz_in = cz_ff[j] + at;
            end else begin
               cx_in = cx_ff[j] - (cy_ff[j] >>> j);
               cy_in = cy_ff[j] + (cx_ff[j] >>> j);
               cz_in = cz_ff[j] - at;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_ff[j+1] <= v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            zr_ff[j+1] <= zr_ff[j];
            sn_ff[j+1] <= sn_in;
            sr_ff[j+1] <= sr_in;
            cx_ff[j+1] <= cx_in;
            cy_ff[j+1] <= cy_in;
            cz_ff[j+1] <= cz_in;
         end
      end
   end

   // Final stage: round the angle, clamp, and hold as the output register.
   logic signed [ZW-1:0] zrnd;
   logic signed [15:0]   angle_in;
   logic                 out_valid_ff;
   logic [15:0]          speed_ff;
   logic signed [15:0]   angle_ff;

   always_comb begin
      zrnd = (cz_ff[N] + ZW'(32768)) >>> 16;
      if (zr_ff[N]) begin
         angle_in = '0;
      end else if (zrnd > ZW'(swa_pkg::ANG_LIM)) begin
         angle_in = 16'(swa_pkg::ANG_LIM);
      end else if (zrnd < -ZW'(swa_pkg::ANG_LIM)) begin
         angle_in = -16'(swa_pkg::ANG_LIM);
      end else begin
         angle_in = zrnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         speed_ff <= sr_ff[N][15:0];
         angle_ff <= angle_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign speed     = speed_ff;
   assign angle     = angle_ff;

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (angle <= 16'sd18000 && angle >= -16'sd18000))
      else $error("steering angle out of range");

   // Only the zero vector has zero magnitude, and it must give angle zero.
   a_zero_angle : assert property (@(posedge clock) disable iff (reset)
      (out_valid && speed == 16'd0) |-> angle == 16'sd0)
      else $error("zero vector with nonzero angle");

endmodule

FILE: rtl/swerve3_wheel_speed_angle_top.sv
// Top level of the three-wheel swerve inverse kinematics block: stream ports,
// radius register, kinematics front end and three wheel pipelines.
// Depends on swa_pkg, swa_kin and swa_wheel.
//
//   channel   direction  payload
//   req_*     in         vel_x, vel_y, vel_w (tdata, 48 bits)
//   rsp_*     out        speed/angle for wheels a, b, c (tdata, 96 bits)
//   csr_*     in         wheel_radius_mm (10 bits, write only)
//
// One item enters per cycle unless rsp_tready stalls the pipeline; data passes the
// kinematics stages, the per-bit root and CORDIC stages (16 steps each) and outputs.
// Reset clears the valid bits and loads the radius with 300.
// When rsp_tready is low with a result pending, the whole pipeline holds,
// empty stages included, and req_tready drops in the same cycle.
module swerve3_wheel_speed_angle_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // vel_x, vel_y, vel_w
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // speed_a, angle_a, speed_b, angle_b, speed_c, angle_c
   input  logic        csr_we,
   input  logic [9:0]  csr_wdata
);

   logic [9:0] radius_ff;
   logic       en;
   logic       kin_valid;
   logic       va, vb, vc;
   logic signed [15:0] xa, ya, xb, yb, xc, yc;
   logic [15:0]        speed_a, speed_b, speed_c;
   logic signed [15:0] angle_a, angle_b, angle_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 10'(swa_pkg::RADIUS_RESET);
      end else if (csr_we) begin
         radius_ff <= csr_wdata;
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   swa_kin u_kin (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .vel_x     (req_tdata[15:0]),
      .vel_y     (req_tdata[31:16]),
      .vel_w     (req_tdata[47:32]),
      .radius    (radius_ff),
      .out_valid (kin_valid),
      .xa        (xa),
      .ya        (ya),
      .xb        (xb),
      .yb        (yb),
      .xc        (xc),
      .yc        (yc)
   );

   swa_wheel u_wheel_a (
      .clock (clock), .reset (reset), .en (en), .in_valid (kin_valid),
      .x (xa), .y (ya), .out_valid (va), .speed (speed_a), .angle (angle_a)
   );

   swa_wheel u_wheel_b (
      .clock (clock), .reset (reset), .en (en), .in_valid (kin_valid),
      .x (xb), .y (yb), .out_valid (vb), .speed (speed_b), .angle (angle_b)
   );

   swa_wheel u_wheel_c (
      .clock (clock), .reset (reset), .en (en), .in_valid (kin_valid),
      .x (xc), .y (yc), .out_valid (vc), .speed (speed_c), .angle (angle_c)
   );

   assign rsp_tvalid = va;
   assign rsp_tdata  = {angle_c, speed_c, angle_b, speed_b, angle_a, speed_a};

   // The three wheel pipelines run in lockstep.
   a_lockstep : assert property (@(posedge clock) disable iff (reset)
      (va == vb) && (vb == vc))
      else $error("wheel pipelines out of step");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
